/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned LimW     = 7;
  localparam int unsigned FillW    = 7;
  localparam int unsigned DataW    = 32;
  localparam logic [LimW-1:0] LimReset = 7'd5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Per-cell load control: take right neighbour (pop), else left neighbour, else new word.
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     new_i,
  input  wire entry_t     left_i,
  input  wire entry_t     right_i,
  output entry_t          entry_o,
  output logic            greater_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    if (ctrl_i.from_right) begin
      entry_d = right_i;
    end else if (ctrl_i.from_left) begin
      entry_d = left_i;
    end else begin
      entry_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= entry_d;
    end
  end

  // Stored entry ranks behind the incoming one.
  assign greater_o = $signed(entry_q.prio) > $signed(new_i.prio);
  assign entry_o   = entry_q;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue built as a row of 64 shifting cells, head in cell 0.
// Command channel: func_i, item_data_i and item_priority_i are taken at a
// clock edge with start high and busy low. busy is always low: every
// command completes in the cycle it is taken, so one word per cycle is
// sustained, back to back.
// Result channel: one word per command, shown for one cycle with done_o high,
// the cycle after the command edge. The receiver cannot stall.
// Insert: every cell compares its priority with the new one in parallel; the
// cells behind the new position move one place up and the gap takes the word.
// Remove: every cell takes its right neighbour's entry, cell 0 leaves.
// Config: cfg_data_i sets the capacity limit when cfg_valid_i is high;
// cfg_ready_o is always high. Write only while no command is in flight.
// Reset clears the fill count and sets the limit to 5; cell contents are not
// cleared, only entries below the count are ever read.
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    func_i,
  input  wire logic signed [DataW-1:0] item_data_i,
  input  wire logic signed [DataW-1:0] item_priority_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [LimW-1:0]         cfg_data_i,
  output logic                         done_o,
  output logic signed [DataW-1:0]      out_data_o,
  output logic signed [DataW-1:0]      out_priority_o,
  output logic [1:0]                   status_o,
  output logic [FillW-1:0]             fill_count_o,
  output logic                         is_full_o,
  output logic                         is_empty_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [LimW-1:0] limit_q;
  logic [CntW-1:0] lim;

  logic accept, full_now, empty_now, do_ins, do_rem;

  entry_t     new_entry;
  entry_t     cell_entry [Capacity];
  logic       greater [Capacity];
  logic       pass [Capacity];
  cell_ctrl_t ctrl [Capacity];

  logic                    done_q;
  entry_t                  out_q, out_d;
  status_e                 status_q, status_d;
  logic [FillW-1:0]        fill_q;
  logic                    full_q, empty_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_comb begin
    if (int'(limit_q) > int'(Capacity)) begin
      lim = CntW'(Capacity);
    end else begin
      lim = CntW'(limit_q);
    end
  end

  assign full_now  = count_q >= lim;
  assign empty_now = count_q == '0;
  assign do_ins    = accept && (func_i == FUNC_INSERT) && !full_now;
  assign do_rem    = accept && (func_i == FUNC_REMOVE) && !empty_now;

  assign new_entry.data = item_data_i;
  assign new_entry.prio = item_priority_i;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic occ, at_end;
    entry_t left_in, right_in;

    assign occ    = CntW'(i) < count_q;
    assign at_end = CntW'(i) == count_q;
    assign pass[i] = occ && greater[i];

    if (i == 0) begin : g_head
      assign left_in          = new_entry;
      assign ctrl[i].from_left = 1'b0;
    end else begin : g_body
      assign left_in          = cell_entry[i-1];
      assign ctrl[i].from_left = pass[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_in = cell_entry[i];
    end else begin : g_inner
      assign right_in = cell_entry[i+1];
    end

    assign ctrl[i].from_right = do_rem;
    assign ctrl[i].load       = (do_ins && (pass[i] || at_end)) || do_rem;

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .new_i     (new_entry),
      .left_i    (left_in),
      .right_i   (right_in),
      .entry_o   (cell_entry[i]),
      .greater_o (greater[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    out_d    = '0;
    status_d = ST_INSERTED;
    if (func_i == FUNC_INSERT) begin
      if (full_now) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty_now) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_REMOVED;
        out_d    = cell_entry[0];
        count_d  = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LimReset;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q    <= out_d;
      status_q <= status_d;
      fill_q   <= FillW'(count_d);
      full_q   <= count_d >= lim;
      empty_q  <= count_d == '0;
    end
  end

  assign done_o         = done_q;
  assign out_data_o     = out_q.data;
  assign out_priority_o = out_q.prio;
  assign status_o       = status_q;
  assign fill_count_o   = fill_q;
  assign is_full_o      = full_q;
  assign is_empty_o     = empty_q;

  `ASSERT_CLK(a_count_bound, int'(count_q) <= int'(Capacity), "fill count beyond capacity")
  `ASSERT_CLK(a_one_result, accept |=> done_o, "command without result")
  `ASSERT_CLK(a_no_spurious, !accept |=> !done_o, "result without command")
  `ASSERT_CLK(a_insert_nonempty, (done_o && status_o == ST_INSERTED) |-> !is_empty_o,
              "insert left queue empty")
  `ASSERT_CLK(a_reject_keeps, (accept && !do_ins && !do_rem) |=> $stable(count_q),
              "rejected command changed the count")

endmodule

`default_nettype wire

/* test/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QuietLimit = 500;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic signed [DataW-1:0] prio;
    status_e                 status;
    logic [FillW-1:0]        fill;
    logic                    full;
    logic                    empty;
  } pq_result_t;

  // Sorted shelf of stored entries, head at index 0, and the words still due.
  class pq_scoreboard;
    entry_t          shelf[$];
    logic [LimW-1:0] limit;
    pq_result_t      awaited[$];
    int unsigned     mismatches;
    int unsigned     commands;
    int unsigned     status_seen[4];

    function new();
      limit      = LimReset;
      mismatches = 0;
      commands   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_limit(logic [LimW-1:0] v);
      limit = v;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_command(func_e f, logic signed [DataW-1:0] d,
                               logic signed [DataW-1:0] p);
      pq_result_t  r;
      entry_t      e;
      int unsigned eff;
      int          pos;
      eff = (limit > Capacity) ? Capacity : limit;
      r = '0;
      if (f == FUNC_INSERT) begin
        if (shelf.size() >= eff) begin
          r.status = ST_FULL;
        end else begin
          // land behind every entry of equal priority
          pos = shelf.size();
          while (pos > 0 && $signed(shelf[pos-1].prio) > $signed(p)) pos--;
          e.data = d;
          e.prio = p;
          shelf.insert(pos, e);
          r.status = ST_INSERTED;
        end
      end else if (shelf.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e = shelf.pop_front();
        r.data   = e.data;
        r.prio   = e.prio;
        r.status = ST_REMOVED;
      end
      r.fill  = FillW'(shelf.size());
      r.full  = shelf.size() >= eff;
      r.empty = shelf.size() == 0;
      awaited.push_back(r);
      commands++;
    endfunction

    function void compare(string name, logic [DataW-1:0] e, logic [DataW-1:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %h actual %h", $time, name, e, a);
        mismatches++;
      end
    endfunction

    function void check_result(pq_result_t a);
      pq_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word, expected none actual status %0d fill %0d",
                 $time, a.status, a.fill);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      status_seen[e.status]++;
      compare("out_data", e.data, a.data);
      compare("out_priority", e.prio, a.prio);
      compare("status", DataW'(e.status), DataW'(a.status));
      compare("fill_count", DataW'(e.fill), DataW'(a.fill));
      compare("is_full", DataW'(e.full), DataW'(a.full));
      compare("is_empty", DataW'(e.empty), DataW'(a.empty));
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  func_e                   func_i;
  logic signed [DataW-1:0] item_data_i;
  logic signed [DataW-1:0] item_priority_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [LimW-1:0]         cfg_data_i;
  logic                    done_o;
  logic signed [DataW-1:0] out_data_o;
  logic signed [DataW-1:0] out_priority_o;
  logic [1:0]              status_o;
  logic [FillW-1:0]        fill_count_o;
  logic                    is_full_o;
  logic                    is_empty_o;

  pq_scoreboard sb;
  int unsigned  quiet_cycles = 0;
  int unsigned  limits_written = 0;

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .item_data_i    (item_data_i),
    .item_priority_i(item_priority_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .out_data_o     (out_data_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    pq_result_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.data   = out_data_o;
        got.prio   = out_priority_o;
        got.status = status_e'(status_o);
        got.fill   = fill_count_o;
        got.full   = is_full_o;
        got.empty  = is_empty_o;
        sb.check_result(got);
      end
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog, no progress for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send(func_e f, logic signed [DataW-1:0] d, logic signed [DataW-1:0] p);
    func_i          <= f;
    item_data_i     <= d;
    item_priority_i <= p;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_command(f, d, p);
  endtask

  task automatic pause(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold off until every word has come back, plus the pipeline stage
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimW-1:0] v);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
    limits_written++;
  endtask

  // mostly a narrow band so ties are common, plus full range and the edges
  function automatic logic signed [DataW-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 16)) - 8;
      6, 7:             return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return ($urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0000)
                      + $urandom_range(0, 15);
    endcase
  endfunction

  task automatic burst(int unsigned n, bit gaps);
    int unsigned ins_pct;
    func_e       f;
    ins_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      // drift between filling and draining so both full and empty are reached
      if (i % 25 == 0) begin
        case ($urandom_range(0, 3))
          0:       ins_pct = 90;
          1:       ins_pct = 60;
          2:       ins_pct = 40;
          default: ins_pct = 15;
        endcase
      end
      f = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
      send(f, $urandom, pick_priority());
      if (gaps && $urandom_range(0, 99) < 30) pause($urandom_range(1, 2));
    end
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = FUNC_INSERT;
    item_data_i     = '0;
    item_priority_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset limit of five
    send(FUNC_REMOVE, 32'h1234_5678, 32'h0BAD_0BAD);
    send(FUNC_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000);
    send(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send(FUNC_INSERT, 32'h0000_0001, 32'h0000_0000);
    send(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send(FUNC_INSERT, 32'hA5A5_A5A5, 32'h8000_0000);
    repeat (5) send(FUNC_REMOVE, $urandom, $urandom);
    send(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_INSERT, 32'h0000_00AA, 32'd7);
    send(FUNC_INSERT, 32'h0000_00BB, 32'd7);
    send(FUNC_INSERT, 32'h0000_00CC, 32'd3);
    send(FUNC_INSERT, 32'h0000_00DD, 32'd7);
    repeat (5) send(FUNC_REMOVE, '0, '0);

    // full capacity, run back to back with no gaps
    write_limit(7'd64);
    repeat (70) send(FUNC_INSERT, $urandom, pick_priority());
    burst(280, 1'b0);

    // limit beyond capacity saturates
    write_limit(7'd127);
    burst(300, 1'b1);

    // zero limit: every insert bounces, stored entries drain
    write_limit(7'd0);
    burst(40, 1'b1);

    write_limit(7'd1);
    burst(150, 1'b1);

    write_limit(7'd20);
    burst(250, 1'b1);
    wait_quiet();
    burst(100, 1'b1);

    // lower the limit beneath the current fill
    write_limit(7'd100);
    repeat (40) send(FUNC_INSERT, $urandom, pick_priority());
    write_limit(7'd3);
    burst(200, 1'b1);

    repeat (4) begin
      write_limit(LimW'($urandom_range(0, 127)));
      burst(100, 1'b1);
    end

    wait_quiet();
    $display("ran %0d commands across %0d limit settings", sb.commands, limits_written + 1);
    $display("inserted %0d, bounced full %0d, removed %0d, removed on empty %0d",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_FULL],
             sb.status_seen[ST_REMOVED], sb.status_seen[ST_EMPTY]);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
